// ----- hw/rtl/playfair_cipher_encrypt_core_macros.svh -----
// ----------------------------------------------------------------------------
// playfair encryptor assertion macros
// shared property wrappers, clocked on clk and disabled during arst_n
// ----------------------------------------------------------------------------
`ifndef PLAYFAIR_CIPHER_ENCRYPT_CORE_MACROS_SVH
`define PLAYFAIR_CIPHER_ENCRYPT_CORE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define PCE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PCE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ----- hw/rtl/pce_pkg.sv -----
// ----------------------------------------------------------------------------
// pce_pkg
// types, constants and helper functions of the playfair encryptor
// ----------------------------------------------------------------------------
package pce_pkg;

	localparam int SQUARE_SIDE = 5;
	localparam int SQUARE_SIZE = SQUARE_SIDE * SQUARE_SIDE;
	localparam int ALPHABET    = 26;

	typedef logic [4:0] letter_t;
	typedef logic [4:0] slot_t;
	typedef logic [2:0] coord_t;
	typedef logic [6:0] ascii_t;

	localparam letter_t LETTER_Q = 5'd16;
	localparam letter_t LETTER_X = 5'd23;
	localparam logic [ALPHABET-1:0] USED_RESET = 26'(1) << LETTER_Q;

	typedef enum logic [1:0] {
		CMD_KEY    = 2'd0,
		CMD_FINISH = 2'd1,
		CMD_TEXT   = 2'd2,
		CMD_END    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FILL,
		ST_POS,
		ST_SQ
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic in_ready;
		logic pos_read;
		logic fill_step;
		logic sq_read;
		logic load_out;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_valid;
		logic finish_cmd;
		logic pair_start;
		logic fill_last;
		logic out_empty;
	} dp_status_t;

	typedef struct packed {
		logic    valid;
		letter_t idx;
	} letter_dec_t;

	// ascii letter of either case to index
	function automatic letter_dec_t letter_decode(logic [7:0] code);
		letter_dec_t d;
		d.valid = 1'b0;
		d.idx   = '0;
		if (code >= 8'd97 && code <= 8'd122) begin
			d.valid = 1'b1;
			d.idx   = letter_t'(code - 8'd97);
		end else if (code >= 8'd65 && code <= 8'd90) begin
			d.valid = 1'b1;
			d.idx   = letter_t'(code - 8'd65);
		end
		return d;
	endfunction

	// row of a slot by threshold compare
	function automatic coord_t slot_row(slot_t s);
		coord_t r;
		r = '0;
		for (int i = 1; i < SQUARE_SIDE; i++) begin
			if (s >= slot_t'(i * SQUARE_SIDE))
				r = coord_t'(i);
		end
		return r;
	endfunction

	function automatic slot_t slot_at(coord_t r, coord_t c);
		return slot_t'(int'(r) * SQUARE_SIDE + int'(c));
	endfunction

	function automatic coord_t slot_col(slot_t s);
		return coord_t'(s - slot_at(slot_row(s), '0));
	endfunction

	// step right or down with wrap
	function automatic coord_t coord_next(coord_t c);
		return (c == coord_t'(SQUARE_SIDE - 1)) ? '0 : coord_t'(c + 3'd1);
	endfunction

	function automatic ascii_t ascii_of(letter_t l);
		return ascii_t'(7'd65 + {2'b00, l});
	endfunction

endpackage

// ----- hw/rtl/pce_in_if.sv -----
// ----------------------------------------------------------------------------
// pce_in_if
// input channel: command and character with valid/ready
// ----------------------------------------------------------------------------
interface pce_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] char_code;

	modport source (output valid, output command, output char_code, input ready);
	modport sink (input valid, input command, input char_code, output ready);
endinterface

// ----- hw/rtl/pce_out_if.sv -----
// ----------------------------------------------------------------------------
// pce_out_if
// output channel: ciphertext letter with valid/ready
// ----------------------------------------------------------------------------
interface pce_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] cipher_char;
	logic       pair_end;

	modport source (output valid, output cipher_char, output pair_end, input ready);
	modport sink (input valid, input cipher_char, input pair_end, output ready);
endinterface

// ----- hw/rtl/pce_datapath.sv -----
// ----------------------------------------------------------------------------
// pce_datapath
// key square memories, digraph pairing, lookup and output buffer
// ----------------------------------------------------------------------------
module pce_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	pce_in_if.sink                 text,
	pce_out_if.source              cipher,
	input  pce_pkg::ctrl_cmd_t     cmd,
	output pce_pkg::dp_status_t    sts
);
	import pce_pkg::*;

	letter_t               square_mem [SQUARE_SIZE];
	slot_t                 pos_mem [ALPHABET];

	logic [ALPHABET-1:0]   letter_used_q;
	slot_t                 fill_index_q;
	letter_t               fill_ctr_q;
	letter_t               pending_letter_q;
	logic                  pending_valid_q;

	slot_t                 pos_a_q;
	slot_t                 pos_b_q;
	letter_t               enc_a_q;
	letter_t               enc_b_q;

	logic                  out_valid_q;
	ascii_t                out_char_q;
	logic                  out_end_q;
	ascii_t                second_char_q;
	logic                  second_pend_q;

	cmd_t                  cmd_in;
	letter_dec_t           dec;
	logic                  accept;
	logic                  text_ok;
	letter_t               pair_b;
	letter_t               place_letter;
	logic                  place_en;
	coord_t                ra, ca, rb, cb;
	slot_t                 slot_a, slot_b;

	// input decode
	always_comb begin
		cmd_in  = cmd_t'(text.command);
		dec     = letter_decode(text.char_code);
		accept  = text.valid && cmd.in_ready;
		text_ok = dec.valid && (dec.idx != LETTER_Q);
		pair_b  = (cmd_in == CMD_TEXT && dec.idx != pending_letter_q) ? dec.idx : LETTER_X;
	end

	assign text.ready = cmd.in_ready;

	// status to controller
	always_comb begin
		sts.in_valid   = text.valid;
		sts.finish_cmd = (cmd_in == CMD_FINISH);
		sts.pair_start = pending_valid_q &&
			((cmd_in == CMD_TEXT && text_ok) || cmd_in == CMD_END);
		sts.fill_last  = (fill_ctr_q == letter_t'(ALPHABET - 1));
		sts.out_empty  = !out_valid_q;
	end

	// letter placement, from key characters or the fill sweep
	always_comb begin
		place_letter = cmd.fill_step ? fill_ctr_q : dec.idx;
		place_en     = ((accept && cmd_in == CMD_KEY && dec.valid) || cmd.fill_step) &&
			!letter_used_q[place_letter] && (fill_index_q < slot_t'(SQUARE_SIZE));
	end

	// key state, fill sweep counter and open digraph
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			letter_used_q    <= USED_RESET;
			fill_index_q     <= '0;
			fill_ctr_q       <= '0;
			pending_letter_q <= '0;
			pending_valid_q  <= 1'b0;
		end else begin
			if (place_en) begin
				letter_used_q[place_letter] <= 1'b1;
				fill_index_q                <= slot_t'(fill_index_q + 5'd1);
			end
			if (accept && cmd_in == CMD_FINISH)
				fill_ctr_q <= '0;
			else if (cmd.fill_step && !sts.fill_last)
				fill_ctr_q <= letter_t'(fill_ctr_q + 5'd1);
			if (accept && cmd_in == CMD_TEXT && text_ok) begin
				if (!pending_valid_q) begin
					pending_letter_q <= dec.idx;
					pending_valid_q  <= 1'b1;
				end else if (dec.idx != pending_letter_q) begin
					pending_valid_q <= 1'b0;
				end
			end else if (accept && cmd_in == CMD_END) begin
				pending_valid_q <= 1'b0;
			end
		end
	end

	// square and position memories with registered reads
	always_ff @(posedge clk) begin
		if (place_en) begin
			square_mem[fill_index_q] <= place_letter;
			pos_mem[place_letter]    <= fill_index_q;
		end
		if (cmd.pos_read) begin
			pos_a_q <= pos_mem[pending_letter_q];
			pos_b_q <= pos_mem[pair_b];
		end
		if (cmd.sq_read) begin
			enc_a_q <= square_mem[slot_a];
			enc_b_q <= square_mem[slot_b];
		end
	end

	// digraph rules: same row, else same column, else rectangle
	always_comb begin
		ra = slot_row(pos_a_q);
		ca = slot_col(pos_a_q);
		rb = slot_row(pos_b_q);
		cb = slot_col(pos_b_q);
		if (ra == rb) begin
			slot_a = slot_at(ra, coord_next(ca));
			slot_b = slot_at(rb, coord_next(cb));
		end else if (ca == cb) begin
			slot_a = slot_at(coord_next(ra), ca);
			slot_b = slot_at(coord_next(rb), cb);
		end else begin
			slot_a = slot_at(ra, cb);
			slot_b = slot_at(rb, ca);
		end
	end

	// two-letter output buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			second_pend_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q   <= 1'b1;
			second_pend_q <= 1'b1;
		end else if (out_valid_q && cipher.ready) begin
			out_valid_q   <= second_pend_q;
			second_pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_char_q    <= ascii_of(enc_a_q);
			out_end_q     <= 1'b0;
			second_char_q <= ascii_of(enc_b_q);
		end else if (out_valid_q && cipher.ready && second_pend_q) begin
			out_char_q <= second_char_q;
			out_end_q  <= 1'b1;
		end
	end

	assign cipher.valid       = out_valid_q;
	assign cipher.cipher_char = out_char_q;
	assign cipher.pair_end    = out_end_q;

endmodule

// ----- hw/rtl/pce_controller.sv -----
// ----------------------------------------------------------------------------
// pce_controller
// sequencer for the fill sweep and the two-step digraph lookup
// ----------------------------------------------------------------------------
`include "playfair_cipher_encrypt_core_macros.svh"

module pce_controller (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pce_pkg::dp_status_t    sts,
	output pce_pkg::ctrl_cmd_t     cmd
);
	import pce_pkg::*;

	state_t state_q;
	state_t state_d;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (sts.in_valid && sts.finish_cmd)
					state_d = ST_FILL;
				else if (sts.in_valid && sts.pair_start)
					state_d = ST_POS;
			end
			ST_FILL: begin
				if (sts.fill_last)
					state_d = ST_IDLE;
			end
			ST_POS: state_d = ST_SQ;
			ST_SQ: begin
				if (sts.out_empty)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// outputs
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				cmd.pos_read = sts.in_valid && sts.pair_start;
			end
			ST_FILL: cmd.fill_step = 1'b1;
			ST_POS:  cmd.sq_read   = 1'b1;
			ST_SQ:   cmd.load_out  = sts.out_empty;
			default: cmd = '0;
		endcase
	end

	`PCE_ASSERT_NEXT(a_pos_then_sq, state_q == ST_POS, state_q == ST_SQ, "lookup skipped square read")
	`PCE_ASSERT_NEXT(a_sq_waits, state_q == ST_SQ && !sts.out_empty, state_q == ST_SQ && !cmd.in_ready, "digraph left before output buffer drained")
	`PCE_ASSERT_NEXT(a_fill_runs, state_q == ST_FILL && !sts.fill_last, state_q == ST_FILL, "fill sweep cut short")
	`PCE_ASSERT_NEXT(a_pair_lookup, cmd.pos_read, state_q == ST_POS && !cmd.in_ready, "digraph transaction did not start lookup")

endmodule

// ----- hw/rtl/playfair_cipher_encrypt_core.sv -----
// ----------------------------------------------------------------------------
// playfair_cipher_encrypt_core
// playfair encryptor with a 5x5 key square without Q
// ----------------------------------------------------------------------------
// Send key characters (command 0), then one finish (command 1), then plaintext
// characters (command 2) and an end of message (command 3). Key characters and
// plaintext letters that do not complete a digraph need no lookup. Finish runs
// a sweep over the alphabet, one letter per cycle. A transaction that completes
// a digraph runs a position memory read, a square memory read and a load into
// the two-letter output buffer, in that order; the load waits for the buffer to
// drain. Each digraph leaves as two transactions on cipher, the second marked
// with pair_end. Non-letters and Q are dropped.
// ----------------------------------------------------------------------------
module playfair_cipher_encrypt_core (
	input  logic       clk,
	input  logic       arst_n,
	pce_in_if.sink     text,
	pce_out_if.source  cipher
);
	import pce_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t sts;

	// sequencer
	pce_controller u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// square, pairing and output
	pce_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.cipher (cipher),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule

// ----- verif/tb_playfair_cipher_encrypt_core.sv -----
// ----------------------------------------------------------------------------
// tb_playfair_cipher_encrypt_core
// self-checking bench: builds one key square, then streams plaintext through
// the encryptor under random backpressure and compares every ciphertext
// transaction with an in-bench playfair model
// ----------------------------------------------------------------------------
module tb_playfair_cipher_encrypt_core;
	import pce_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		cmd_t       command;
		logic [7:0] char_code;
	} text_item_t;

	typedef struct {
		ascii_t letter;
		logic   last;
	} cipher_exp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pce_in_if  plain_if ();
	pce_out_if cipher_if ();

	playfair_cipher_encrypt_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (plain_if),
		.cipher (cipher_if)
	);

	// stimulus and scoreboard bookkeeping
	text_item_t  text_feed_q[$];
	cipher_exp_t expected_cipher_q[$];
	int          items_queued = 0;
	int          items_taken = 0;
	int          failures = 0;
	int          cycle_count = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	logic        text_taken = 1'b0;

	// model state of the key square and the open digraph
	letter_t             key_square[SQUARE_SIZE] = '{default: '0};
	int                  slot_of[ALPHABET] = '{default: 0};
	logic [ALPHABET-1:0] used_mask = USED_RESET;
	int                  fill_slot = 0;
	letter_t             open_letter = '0;
	logic                open_valid = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// letter index of either case, -1 for anything else
	function automatic int letter_index(logic [7:0] code);
		if (code >= 8'd97 && code <= 8'd122)
			return int'(code) - 97;
		if (code >= 8'd65 && code <= 8'd90)
			return int'(code) - 65;
		return -1;
	endfunction

	function automatic void place_in_square(int l);
		if (used_mask[l] || fill_slot >= SQUARE_SIZE)
			return;
		key_square[fill_slot] = letter_t'(l);
		slot_of[l] = fill_slot;
		used_mask[l] = 1'b1;
		fill_slot++;
	endfunction

	// row rule first, then column rule, else rectangle
	function automatic void encrypt_digraph(letter_t a, letter_t b);
		int ra, ca, rb, cb;
		letter_t ea, eb;
		cipher_exp_t e;
		ra = slot_of[a] / SQUARE_SIDE;
		ca = slot_of[a] % SQUARE_SIDE;
		rb = slot_of[b] / SQUARE_SIDE;
		cb = slot_of[b] % SQUARE_SIDE;
		if (ra == rb) begin
			ea = key_square[ra * SQUARE_SIDE + (ca + 1) % SQUARE_SIDE];
			eb = key_square[rb * SQUARE_SIDE + (cb + 1) % SQUARE_SIDE];
		end else if (ca == cb) begin
			ea = key_square[((ra + 1) % SQUARE_SIDE) * SQUARE_SIDE + ca];
			eb = key_square[((rb + 1) % SQUARE_SIDE) * SQUARE_SIDE + cb];
		end else begin
			ea = key_square[ra * SQUARE_SIDE + cb];
			eb = key_square[rb * SQUARE_SIDE + ca];
		end
		e.letter = ascii_t'(7'd65 + 7'(ea));
		e.last   = 1'b0;
		expected_cipher_q = {expected_cipher_q, e};
		e.letter = ascii_t'(7'd65 + 7'(eb));
		e.last   = 1'b1;
		expected_cipher_q = {expected_cipher_q, e};
	endfunction

	function automatic void predict_playfair(cmd_t cmd, logic [7:0] code);
		int l;
		l = letter_index(code);
		case (cmd)
			CMD_KEY: begin
				if (l >= 0)
					place_in_square(l);
			end
			CMD_FINISH: begin
				for (int k = 0; k < ALPHABET; k++)
					place_in_square(k);
			end
			CMD_TEXT: begin
				if (l >= 0 && letter_t'(l) != LETTER_Q) begin
					if (!open_valid) begin
						open_letter = letter_t'(l);
						open_valid  = 1'b1;
					end else if (open_letter == letter_t'(l)) begin
						// doubled letter: pad with X, letter stays open
						encrypt_digraph(open_letter, LETTER_X);
					end else begin
						open_valid = 1'b0;
						encrypt_digraph(open_letter, letter_t'(l));
					end
				end
			end
			default: begin
				if (open_valid) begin
					open_valid = 1'b0;
					encrypt_digraph(open_letter, LETTER_X);
				end
			end
		endcase
	endfunction

	// input driver, changes at the falling edge
	always @(negedge clk) begin : text_driver
		text_item_t nxt;
		if (arst_n && (!plain_if.valid || text_taken)) begin
			if (text_feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = text_feed_q.pop_front();
				plain_if.valid     <= 1'b1;
				plain_if.command   <= nxt.command;
				plain_if.char_code <= nxt.char_code;
			end else begin
				plain_if.valid     <= 1'b0;
				plain_if.command   <= 2'($urandom_range(3));
				plain_if.char_code <= 8'($urandom_range(255));
			end
		end
	end

	// receiver backpressure
	always @(negedge clk) begin
		cipher_if.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// monitor: predict on input transactions, check output transactions
	always @(posedge clk) begin : monitor
		cipher_exp_t want;
		cycle_count++;
		text_taken <= arst_n && plain_if.valid && plain_if.ready;
		if (arst_n && plain_if.valid && plain_if.ready) begin
			predict_playfair(cmd_t'(plain_if.command), plain_if.char_code);
			items_taken++;
		end
		if (arst_n && cipher_if.valid && cipher_if.ready) begin
			if (expected_cipher_q.size() == 0) begin
				$display("%0t: unexpected cipher transaction, got %c pair_end %0b",
					$time, cipher_if.cipher_char, cipher_if.pair_end);
				failures++;
			end else begin
				want = expected_cipher_q.pop_front();
				if (cipher_if.cipher_char !== want.letter ||
					cipher_if.pair_end !== want.last) begin
					$display("%0t: cipher mismatch, expected %c pair_end %0b, got %c pair_end %0b",
						$time, want.letter, want.last,
						cipher_if.cipher_char, cipher_if.pair_end);
					failures++;
				end
			end
		end
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	task automatic queue_item(cmd_t cmd, logic [7:0] code);
		text_item_t it;
		it.command   = cmd;
		it.char_code = code;
		text_feed_q = {text_feed_q, it};
		items_queued++;
	endtask

	function automatic logic [7:0] random_letter_code(int l);
		return 8'(l + ($urandom_range(1) ? 97 : 65));
	endfunction

	// mostly letter streams, with doubled letters, ends and some noise
	task automatic queue_random_text(int count);
		int n, r, l;
		n = 0;
		while (n < count) begin
			r = $urandom_range(99);
			l = $urandom_range(ALPHABET - 1);
			if (r < 60) begin
				queue_item(CMD_TEXT, random_letter_code(l));
				n++;
			end else if (r < 70) begin
				queue_item(CMD_TEXT, random_letter_code(l));
				queue_item(CMD_TEXT, random_letter_code(l));
				n += 2;
			end else if (r < 74) begin
				queue_item(CMD_TEXT, random_letter_code(LETTER_X));
				queue_item(CMD_TEXT, random_letter_code(LETTER_X));
				n += 2;
			end else if (r < 82) begin
				queue_item(CMD_TEXT, 8'($urandom_range(255)));
				n++;
			end else if (r < 90) begin
				queue_item(CMD_END, 8'($urandom_range(255)));
				n++;
			end else if (r < 95) begin
				queue_item(CMD_KEY, 8'($urandom_range(255)));
			end else begin
				queue_item(CMD_FINISH, 8'($urandom_range(255)));
			end
		end
	endtask

	// every transaction taken and every ciphertext letter seen
	task automatic wait_drained();
		do
			@(negedge clk);
		while (items_taken != items_queued || expected_cipher_q.size() != 0);
	endtask

	initial begin
		plain_if.valid     = 1'b0;
		plain_if.command   = CMD_KEY;
		plain_if.char_code = 8'h00;
		cipher_if.ready    = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 15;
		recv_idle_pct = 83;

		// key: non-letters, mixed case, repeats and Q
		queue_item(CMD_KEY, 8'h00);
		queue_item(CMD_KEY, 8'hFF);
		queue_item(CMD_KEY, 8'h40);
		queue_item(CMD_KEY, 8'h7B);
		queue_item(CMD_KEY, "P");
		queue_item(CMD_KEY, "l");
		queue_item(CMD_KEY, "a");
		queue_item(CMD_KEY, "Y");
		queue_item(CMD_KEY, "A");
		queue_item(CMD_KEY, "q");
		queue_item(CMD_KEY, "z");
		repeat ($urandom_range(20))
			queue_item(CMD_KEY, 8'($urandom_range(255)));
		// finish twice, then a key letter once the square is full
		queue_item(CMD_FINISH, 8'h00);
		queue_item(CMD_FINISH, 8'hFF);
		queue_item(CMD_KEY, "m");

		// doubled letter, X pair, padded end, empty end, Q and non-letters
		queue_item(CMD_TEXT, "a");
		queue_item(CMD_TEXT, "A");
		queue_item(CMD_TEXT, "b");
		queue_item(CMD_TEXT, "x");
		queue_item(CMD_TEXT, "X");
		queue_item(CMD_END, 8'h00);
		queue_item(CMD_END, 8'hFF);
		queue_item(CMD_TEXT, "q");
		queue_item(CMD_TEXT, 8'h5B);
		queue_item(CMD_TEXT, "z");
		queue_item(CMD_END, "a");
		queue_random_text(310);
		wait_drained();

		// sender pauses until all ciphertext is out, then roles swap
		@(posedge clk);
		send_idle_pct = 83;
		recv_idle_pct = 15;
		queue_random_text(310);
		wait_drained();

		@(posedge clk);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random_text(310);
		queue_item(CMD_END, 8'h00);
		wait_drained();

		// catch stray transactions after the last expected one
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
